/* hw/rtl/ubbe_pkg.sv */
// Shared widths, coefficient table and types of the uniform B-spline basis evaluator.
package ubbe_pkg;

  localparam int X_W        = 16;  // input sample, signed Q2.14
  localparam int B_W        = 15;  // basis value, unsigned Q0.15
  localparam int BASIS_CNT  = 7;
  localparam int NUM_PIECES = 5;
  localparam int NUM_COEF   = 5;
  localparam int FRAC_W     = 14;
  localparam int IDX_W      = 4;   // interval index 0..10
  localparam int U_W        = 20;  // 5 * (x + 1.0) in Q.14, signed
  localparam int SQ_W       = 2 * FRAC_W;
  localparam int CU_W       = 3 * FRAC_W;
  localparam int QU_W       = 4 * FRAC_W;
  localparam int ACC_W      = 62;  // polynomial value scaled by 2^56, modular
  localparam int RND_SHIFT  = 44;  // 24 * 2^41 = 3 * 2^44
  localparam int N_W        = 17;  // quotient by 2^44 before the divide by three
  localparam int RCP_W      = 18;
  localparam int PROD_W     = N_W + RCP_W;
  localparam int TDATA_O_W  = ((BASIS_CNT * B_W + 7) / 8) * 8;

  localparam logic [U_W-1:0]   SPAN_LIMIT = U_W'(11 * 16384);
  localparam logic [U_W-1:0]   ONE_Q14    = U_W'(16384);
  localparam logic [N_W-1:0]   SAT_N      = N_W'(3 * 32768);
  localparam logic [RCP_W-1:0] RECIP3     = RCP_W'(87382);  // ceil(2^18 / 3)
  localparam logic [B_W-1:0]   OUT_MAX    = {B_W{1'b1}};

  typedef logic [ACC_W-1:0] acc_t;
  typedef logic [B_W-1:0]   basis_t;

  localparam acc_t RND = acc_t'(3) << 43;

  // Cardinal quartic pieces, 24 * B = c0 f^4 + c1 f^3 + c2 f^2 + c3 f + c4
  localparam logic signed [5:0] COEF [NUM_PIECES][NUM_COEF] = '{
    '{6'sd1,  6'sd0,   6'sd0,  6'sd0,   6'sd0},
    '{-6'sd4, 6'sd4,   6'sd6,  6'sd4,   6'sd1},
    '{6'sd6,  -6'sd12, -6'sd6, 6'sd12,  6'sd11},
    '{-6'sd4, 6'sd12,  -6'sd6, -6'sd12, 6'sd11},
    '{6'sd1,  -6'sd4,  6'sd6,  -6'sd4,  6'sd1}
  };

  // Load enables of the polynomial stages
  typedef struct packed {
    logic sum_a;
    logic sum_b;
    logic quot;
  } poly_en_t;

  function automatic acc_t scale(input acc_t t, input logic signed [5:0] c);
    acc_t cx;
    cx = acc_t'(c);
    return t * cx;
  endfunction

endpackage

/* hw/rtl/ubbe_poly.sv */
// Evaluation of the five quartic pieces, scaling, rounding and saturation.
module ubbe_poly (
  input  logic                         clk,
  input  ubbe_pkg::poly_en_t           en,
  input  logic [ubbe_pkg::FRAC_W-1:0]  frac,
  input  logic [ubbe_pkg::SQ_W-1:0]    frac_sq,
  input  logic [ubbe_pkg::CU_W-1:0]    frac_cu,
  input  logic [ubbe_pkg::QU_W-1:0]    frac_qu,
  output ubbe_pkg::basis_t             piece [ubbe_pkg::NUM_PIECES]
);
  import ubbe_pkg::*;

  acc_t t1, t2, t3, t4;
  acc_t hi  [NUM_PIECES];
  acc_t lo  [NUM_PIECES];
  acc_t sum [NUM_PIECES];

  // Terms of the polynomial at the common scale 2^56
  assign t1 = acc_t'(frac) << (3 * FRAC_W);
  assign t2 = acc_t'(frac_sq) << (2 * FRAC_W);
  assign t3 = acc_t'(frac_cu) << FRAC_W;
  assign t4 = acc_t'(frac_qu);

  for (genvar p = 0; p < NUM_PIECES; p++) begin : g_piece
    logic [N_W-1:0]    n;
    logic [PROD_W-1:0] prod;

    assign n    = sum[p][RND_SHIFT+N_W-1:RND_SHIFT];
    assign prod = PROD_W'(n) * PROD_W'(RECIP3);

    always_ff @(posedge clk) begin
      if (en.sum_a) begin
        hi[p] <= scale(t4, COEF[p][0]) + scale(t3, COEF[p][1]);
        lo[p] <= scale(t2, COEF[p][2]) + scale(t1, COEF[p][3])
                 + (acc_t'(COEF[p][4]) << (4 * FRAC_W)) + RND;
      end
      if (en.sum_b) begin
        sum[p] <= hi[p] + lo[p];
      end
      // floor(n / 3) by reciprocal; exact for n below 2^17
      if (en.quot) begin
        if (n >= SAT_N) begin
          piece[p] <= OUT_MAX;
        end else begin
          piece[p] <= prod[RCP_W+B_W-1:RCP_W];
        end
      end
    end
  end

endmodule

/* hw/rtl/uniform_bspline_basis_eval.sv */
// Top level of the uniform quartic B-spline basis evaluator.
//
// Each input item is one sample x (signed Q2.14); each result item holds the
// seven quartic B-spline basis values B_0..B_6 (unsigned Q0.15) on the uniform
// knot grid t_j = -1 + 0.2*j, j = 0..11. A sample outside [-1, 1.2) gives all
// zeros; a sample exactly on a knot belongs to the interval on its right.
// The block is a seven-stage pipeline: it takes one item every cycle unless
// the output side stalls. Stage 1 splits 5*(x+1) into an interval index and
// a 14-bit fraction f, stages 2 and 3 form f^2, f^3 and f^4 (one multiplier
// level each), stages 4 to 6 sum the five polynomial pieces exactly and
// divide by 24 with round-to-nearest, and stage 7 routes the pieces to the
// bases and holds the result. Every stage has its own valid bit and loads
// whenever it is empty or its successor loads, so bubbles close up and a
// stall on the output side holds everything without loss.
module uniform_bspline_basis_eval (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ubbe_pkg::X_W-1:0]        s_axis_tdata,   // [15:0] x_value
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [14:0] basis_0, [29:15] basis_1, [44:30] basis_2, [59:45] basis_3,
  // [74:60] basis_4, [89:75] basis_5, [104:90] basis_6, [111:105] zero
  output logic [ubbe_pkg::TDATA_O_W-1:0]  m_axis_tdata
);
  import ubbe_pkg::*;

  localparam int NSTG = 7;

  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;

  // Stage 1 inputs: map x onto the knot grid
  logic signed [U_W-1:0] xs_ext;
  logic signed [U_W-1:0] u_val;
  logic                  u_ok;

  // Index and range flag travel alongside the data through stages 1..6
  logic [IDX_W-1:0]  idx  [1:6];
  logic              rok  [1:6];

  logic [FRAC_W-1:0] frac1, frac2, frac3;
  logic [SQ_W-1:0]   sq2, sq3;
  logic [CU_W-1:0]   cu3;
  logic [QU_W-1:0]   qu3;

  poly_en_t  poly_en;
  basis_t    piece [NUM_PIECES];
  basis_t    basis [BASIS_CNT];

  // Ready ripples back from the output: a stage loads when empty or draining
  always_comb begin
    rdy[NSTG] = m_axis_tready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // u = 5 * (x + 1) in Q.14; the valid span is [0, 11.0)
  assign xs_ext = U_W'(signed'(s_axis_tdata)) + signed'(ONE_Q14);
  assign u_val  = (xs_ext <<< 2) + xs_ext;
  assign u_ok   = !u_val[U_W-1] && (unsigned'(u_val) < SPAN_LIMIT);

  always_ff @(posedge clk) begin
    // Stage 1: split into interval index and fraction
    if (rdy[0]) begin
      idx[1] <= u_val[FRAC_W+IDX_W-1:FRAC_W];
      rok[1] <= u_ok;
      frac1  <= u_val[FRAC_W-1:0];
    end
    // Stage 2: square of the fraction
    if (rdy[1]) begin
      frac2 <= frac1;
      sq2   <= SQ_W'(frac1) * SQ_W'(frac1);
    end
    // Stage 3: cube and fourth power
    if (rdy[2]) begin
      frac3 <= frac2;
      sq3   <= sq2;
      cu3   <= CU_W'(sq2) * CU_W'(frac2);
      qu3   <= QU_W'(sq2) * QU_W'(sq2);
    end
    // Advance index and range flag alongside the data
    for (int k = 2; k <= 6; k++) begin
      if (rdy[k-1]) begin
        idx[k] <= idx[k-1];
        rok[k] <= rok[k-1];
      end
    end
    // Stage 7: pick the active piece for every basis, drop the rest
    if (rdy[6]) begin
      for (int i = 0; i < BASIS_CNT; i++) begin
        if (rok[6] && (idx[6] >= IDX_W'(i)) && (idx[6] - IDX_W'(i) < IDX_W'(NUM_PIECES))) begin
          basis[i] <= piece[3'(idx[6] - IDX_W'(i))];
        end else begin
          basis[i] <= '0;
        end
      end
    end
  end

  assign poly_en.sum_a = rdy[3];
  assign poly_en.sum_b = rdy[4];
  assign poly_en.quot  = rdy[5];

  ubbe_poly u_poly (
    .clk     (clk),
    .en      (poly_en),
    .frac    (frac3),
    .frac_sq (sq3),
    .frac_cu (cu3),
    .frac_qu (qu3),
    .piece   (piece)
  );

  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < BASIS_CNT; i++) begin
      m_axis_tdata[i*B_W +: B_W] = basis[i];
    end
  end

endmodule
